// ===== sv/falc_pkg.sv =====
package falc_pkg;

  localparam int KEY_W      = 64;
  localparam int PAY_W      = 32;
  localparam int LEN_W      = 17;
  localparam int STAMP_W    = 31;
  localparam int SLOT_W     = 4;
  localparam int IN_DATA_W  = 144;
  localparam int IN_USER_W  = 1;
  localparam int OUT_DATA_W = 56;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [LEN_W-1:0]   length;
    logic [PAY_W-1:0]   payload;
    logic [KEY_W-1:0]   key;
  } entry_t;

endpackage

// ===== sv/fully_associative_lru_cache_unit.sv =====
// Fully associative LRU cache. Each transaction on the input stream is a lookup
// or an insert (in_tuser) and yields exactly one result transaction. Entries
// live in a single-port synchronous memory that is scanned one entry per cycle;
// valid bits are flip-flops cleared by reset. A lookup that hits entry i, or an
// insert into free entry i, ends its scan at entry i; a miss, or an insert that
// evicts, scans all ENTRIES entries. The result is registered for out_tvalid once
// any earlier result has been taken, and the next request is accepted after that.
// One transaction is in flight at a time; the result register lets the next
// request start while a result waits on out_tready.
module fully_associative_lru_cache_unit
  import falc_pkg::*;
#(
  parameter int ENTRIES = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [63:0] key, [95:64] payload, [112:96] payload_length, [143:113] stamp
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [0] opcode
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] hit, [4:1] slot, [36:5] found_payload, [53:37] found_length,
  // [54] evicted, [55] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  state_t state_r, state_nxt;

  entry_t             mem [ENTRIES];
  entry_t             rd_data_r;
  entry_t             req_r;
  entry_t             wr_data;
  logic               req_op_r;
  logic [ENTRIES-1:0] valid_r;
  logic [IDX_W-1:0]   idx_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic [STAMP_W-1:0] best_r;
  logic [IDX_W-1:0]   best_idx_r;

  logic               res_hit_r, res_evict_r, res_write_r;
  logic [IDX_W-1:0]   res_idx_r;
  logic [PAY_W-1:0]   res_pay_r;
  logic [LEN_W-1:0]   res_len_r;

  logic               res_hit, res_evict, res_write;
  logic [IDX_W-1:0]   res_idx;
  logic [PAY_W-1:0]   res_pay;
  logic [LEN_W-1:0]   res_len;

  logic               out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic in_fire, match, is_last, older, cur_valid, scan_done, done_ok, done_fire;
  logic [IDX_W+SLOT_W-1:0] slot_ext;

  assign in_fire   = in_tvalid && in_tready;
  assign cur_valid = valid_r[idx_r];
  assign match     = cur_valid && (rd_data_r.key == req_r.key);
  assign is_last   = (idx_r == LAST_IDX);
  assign older     = (idx_r == '0) || (rd_data_r.stamp < best_r);
  assign done_ok   = !out_valid_r || out_tready;
  assign slot_ext  = {{SLOT_W{1'b0}}, res_idx_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_done) state_nxt = ST_DONE;
      ST_DONE: if (done_ok)   state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and scan decisions
  always_comb begin
    in_tready = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = '0;
    scan_done = 1'b0;
    done_fire = 1'b0;
    res_hit   = 1'b0;
    res_evict = 1'b0;
    res_write = 1'b0;
    res_idx   = '0;
    res_pay   = '0;
    res_len   = '0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        rd_en     = in_tvalid;
      end
      ST_SCAN: begin
        rd_en   = !is_last;
        rd_addr = idx_r + IDX_W'(1);
        if (req_op_r == OP_LOOKUP) begin
          scan_done = match || is_last;
          res_hit   = match;
          res_write = match;
          res_idx   = match ? idx_r : '0;
          res_pay   = match ? rd_data_r.payload : '0;
          res_len   = match ? rd_data_r.length : '0;
        end else begin
          scan_done = !cur_valid || is_last;
          res_write = 1'b1;
          res_evict = cur_valid;
          res_idx   = (!cur_valid || older) ? idx_r : best_idx_r;
        end
      end
      ST_DONE: begin
        done_fire = done_ok;
      end
      default: ;
    endcase
  end

  assign wr_data.key     = req_r.key;
  assign wr_data.stamp   = req_r.stamp;
  assign wr_data.payload = (req_op_r == OP_INSERT) ? req_r.payload : res_pay_r;
  assign wr_data.length  = (req_op_r == OP_INSERT) ? req_r.length : res_len_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (done_fire && res_write_r) begin
      mem[res_idx_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (done_fire && res_write_r) begin
        valid_r[res_idx_r] <= 1'b1;
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r    <= entry_t'(in_tdata);
      req_op_r <= in_tuser[0];
      idx_r    <= '0;
    end else if (state_r == ST_SCAN) begin
      if (!is_last) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cur_valid && older) begin
        best_r     <= rd_data_r.stamp;
        best_idx_r <= idx_r;
      end
      if (scan_done) begin
        res_hit_r   <= res_hit;
        res_evict_r <= res_evict;
        res_write_r <= res_write;
        res_idx_r   <= res_idx;
        res_pay_r   <= res_pay;
        res_len_r   <= res_len;
      end
    end
    if (done_fire) begin
      out_data_r <= {1'b0, res_evict_r, res_len_r, res_pay_r,
                     slot_ext[SLOT_W-1:0], res_hit_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_evict_all_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_evict_r) |-> (&valid_r))
    else $error("eviction chosen while a free entry exists");

  a_hit_entry_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && res_hit_r) |-> valid_r[res_idx_r])
    else $error("hit reported on an invalid entry");

  a_hit_not_evict: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> !(res_hit_r && res_evict_r))
    else $error("hit and evict both set");

  a_done_produces_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && done_ok) |=> (out_tvalid && state_r == ST_IDLE))
    else $error("completed transaction did not produce a result");

endmodule

// ===== dv/tb_fully_associative_lru_cache_unit.sv =====
`timescale 1ns / 100ps

module tb_fully_associative_lru_cache_unit
  import falc_pkg::*;
();

  localparam int NUM_ENTRIES = 10;
  localparam int CLK_HALF = 5;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 2 * NUM_ENTRIES + 4;
  localparam int KEY_POOL = 12;
  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic [PAY_W-1:0]  found_payload;
    logic [LEN_W-1:0]  found_length;
    logic              evicted;
  } cache_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = OP_LOOKUP;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // shadow copy of the cache contents
  logic               line_valid [NUM_ENTRIES];
  logic [KEY_W-1:0]   line_key [NUM_ENTRIES];
  logic [PAY_W-1:0]   line_payload [NUM_ENTRIES];
  logic [LEN_W-1:0]   line_length [NUM_ENTRIES];
  logic [STAMP_W-1:0] line_stamp [NUM_ENTRIES];

  cache_result_t      pending_results [$];
  cache_result_t      expected_result;
  logic [KEY_W-1:0]   key_pool [KEY_POOL];
  logic [STAMP_W-1:0] now_stamp = '0;
  int                 error_count = 0;
  int                 send_idle_pct = 0;
  int                 recv_idle_pct = 0;
  longint             cycle_count = 0;

  always #CLK_HALF clk = ~clk;

  fully_associative_lru_cache_unit #(
    .ENTRIES(NUM_ENTRIES)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_stamp[i] = '0;
    end
  end

  task automatic predict_cache_access(input logic op, input logic [KEY_W-1:0] key,
                                      input logic [PAY_W-1:0] pay,
                                      input logic [LEN_W-1:0] len,
                                      input logic [STAMP_W-1:0] stm);
    cache_result_t res;
    int            victim;
    res = '0;
    victim = -1;
    if (op == OP_LOOKUP) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (victim < 0 && line_valid[i] && line_key[i] == key) victim = i;
      end
      if (victim >= 0) begin
        line_stamp[victim] = stm;
        res.hit = 1'b1;
        res.slot = victim[SLOT_W-1:0];
        res.found_payload = line_payload[victim];
        res.found_length = line_length[victim];
      end
    end else begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        if (victim < 0 && !line_valid[i]) victim = i;
      end
      if (victim < 0) begin
        // LRU victim: lowest stamp, lowest index on ties
        victim = 0;
        for (int i = 1; i < NUM_ENTRIES; i++) begin
          if (line_stamp[i] < line_stamp[victim]) victim = i;
        end
        res.evicted = 1'b1;
      end
      line_valid[victim] = 1'b1;
      line_key[victim] = key;
      line_payload[victim] = pay;
      line_length[victim] = len;
      line_stamp[victim] = stm;
      res.slot = victim[SLOT_W-1:0];
    end
    pending_results.push_back(res);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("fully_associative_lru_cache_unit verification failed");
      $finish;
    end else if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing pending: %h", out_tdata);
        error_count++;
      end else begin
        expected_result = pending_results.pop_front();
        check_field("hit", 64'(expected_result.hit), 64'(out_tdata[0]));
        check_field("slot", 64'(expected_result.slot), 64'(out_tdata[4:1]));
        check_field("found_payload", 64'(expected_result.found_payload),
                    64'(out_tdata[36:5]));
        check_field("found_length", 64'(expected_result.found_length),
                    64'(out_tdata[53:37]));
        check_field("evicted", 64'(expected_result.evicted), 64'(out_tdata[54]));
      end
    end
  end

  task automatic send_item(input logic op, input logic [KEY_W-1:0] key,
                           input logic [PAY_W-1:0] pay, input logic [LEN_W-1:0] len,
                           input logic [STAMP_W-1:0] stm);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {stm, len, pay, key};
    do @(posedge clk); while (!in_tready);
    predict_cache_access(op, key, pay, len, stm);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_and_fill();
    logic [KEY_W-1:0] key;
    send_item(OP_LOOKUP, '0, '1, '1, '0);
    for (int i = 0; i < KEY_POOL; i++) key_pool[i] = {$urandom, $urandom};
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      key = (i == 0) ? '0 : (i == 1) ? '1 : key_pool[i];
      key_pool[i] = key;
      send_item(OP_INSERT, key, i[0] ? '1 : '0, i[0] ? '1 : '0, STAMP_MAX);
    end
    send_item(OP_LOOKUP, '1, '0, '0, STAMP_MAX);
    send_item(OP_LOOKUP, '0, '1, '1, STAMP_MAX);
  endtask

  task automatic test_lru_replacement();
    // all stamps at max: slot 0 goes first, then a duplicate key shadows slot 1
    send_item(OP_INSERT, '1, 32'h5a5a_a5a5, 17'h0abcd, STAMP_MAX);
    send_item(OP_LOOKUP, '1, '0, '0, '0);
    send_item(OP_INSERT, key_pool[2], $urandom, LEN_W'($urandom), STAMP_W'(5));
    send_item(OP_LOOKUP, key_pool[2], '0, '0, STAMP_W'(6));
    send_item(OP_LOOKUP, {$urandom, $urandom}, $urandom, LEN_W'($urandom), STAMP_W'(7));
    now_stamp = STAMP_W'(8);
  endtask

  task automatic test_random_traffic(input int n_items);
    logic               op;
    logic [KEY_W-1:0]   key;
    logic [STAMP_W-1:0] stm;
    int                 pick;
    for (int k = 0; k < n_items; k++) begin
      op = ($urandom_range(99) < 40) ? OP_INSERT : OP_LOOKUP;
      if (op == OP_INSERT && $urandom_range(99) < 10)
        key_pool[$urandom_range(KEY_POOL - 1)] = {$urandom, $urandom};
      if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
      else key = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 4) begin
        stm = STAMP_W'($urandom);
      end else if (pick < 6) begin
        stm = STAMP_MAX;
      end else if (pick < 8) begin
        stm = '0;
      end else begin
        now_stamp = now_stamp + STAMP_W'($urandom_range(3));
        stm = now_stamp;
      end
      send_item(op, key, $urandom, LEN_W'($urandom), stm);
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 63;
    test_empty_and_fill();
    test_lru_replacement();
    test_random_traffic(650);
    drain_results();

    send_idle_pct = 63;
    recv_idle_pct = 26;
    test_random_traffic(650);
    drain_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(630);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("fully_associative_lru_cache_unit verification clean");
    end else begin
      $display("fully_associative_lru_cache_unit verification failed");
    end
    $finish;
  end

endmodule
